// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that an antecedent implies a consequent on the next clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
// Assert that an antecedent implies a consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`endif

// File: src/f2i8_pkg.sv
`timescale 1ns / 1ps
package f2i8_pkg;
  localparam int FixW = 6;
  localparam logic [FixW-1:0] FixReset = '0;
  localparam logic SignedReset = 1'b1;
  typedef enum logic [0:0] {
    REG_SCALE_EXP   = 1'b0,
    REG_SIGNED_MODE = 1'b1
  } reg_index_t;
  typedef struct packed {
    logic signed [FixW-1:0] scale_exp;
    logic                   signed_mode;
  } cfg_t;
endpackage

// File: src/float32_to_int8_quantizer.sv
`timescale 1ns / 1ps
// Converts one single-precision word per cycle to an int8 or uint8 byte:
// the value is scaled by 2**scale_exp, rounded to nearest with ties toward
// plus infinity, and saturated; NaN gives 0. Each word passes the input
// register, then the result register; the throughput is one word per cycle
// while out_ready does not stall it, with a single conversion stage between
// the two registers. Configuration is always ready and is applied to the word
// in the input register, so write it only while no word is in flight.
`include "assert_macros.svh"
module float32_to_int8_quantizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] value_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  quantized_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  f2i8_pkg::cfg_t cfg;
  logic        s1_valid;
  logic [31:0] s1_bits;
  logic [7:0]  conv_byte;
  logic        s1_ready;

  f2i8_cfg u_cfg (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
  );
  f2i8_conv u_conv (.value_bits(s1_bits), .cfg, .result(conv_byte));

  assign s1_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s1_ready) out_valid <= s1_valid;
    end
    if (in_ready && in_valid) s1_bits <= value_bits;
    if (s1_ready && s1_valid) quantized_byte <= conv_byte;
  end

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
               out_valid && $stable(quantized_byte), "result word dropped while stalled")
  `ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_ready,
               s1_valid && $stable(s1_bits), "input stage lost a word")
  `ASSERT_SAME(a_nan_zero, clk, rst,
               s1_valid && s1_bits[30:23] == 8'hFF && s1_bits[22:0] != 23'd0,
               conv_byte == 8'd0, "NaN did not give zero")
endmodule

// File: src/f2i8_cfg.sv
`timescale 1ns / 1ps
module f2i8_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output f2i8_pkg::cfg_t     cfg
);
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_exp   <= f2i8_pkg::FixReset;
      cfg.signed_mode <= f2i8_pkg::SignedReset;
    end else if (cfg_valid) begin
      unique case (f2i8_pkg::reg_index_t'(cfg_index))
        f2i8_pkg::REG_SCALE_EXP:   cfg.scale_exp <= cfg_data[f2i8_pkg::FixW-1:0];
        f2i8_pkg::REG_SIGNED_MODE: cfg.signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end
endmodule

// File: src/f2i8_conv.sv
`timescale 1ns / 1ps
// Combinational conversion of one single-precision word to a byte.
module f2i8_conv (
  input  logic [31:0]    value_bits,
  input  f2i8_pkg::cfg_t cfg,
  output logic [7:0]     result
);
  logic              neg;
  logic [7:0]        ex;
  logic [22:0]       frac;
  logic [23:0]       m;
  logic signed [9:0] e;
  logic [8:0]        cap;
  logic [8:0]        mag;
  logic [7:0]        s;
  logic [63:0]       wide;
  logic [63:0]       shifted;
  logic [63:0]       remmask;
  logic [63:0]       rem;
  logic [63:0]       half;
  logic [40:0]       ip;
  logic              bump;
  logic [41:0]       ipr;
  logic [15:0]       ipl;

  always_comb begin
    neg  = value_bits[31];
    ex   = value_bits[30:23];
    frac = value_bits[22:0];
    m    = (ex == 8'd0) ? {1'b0, frac} : {1'b1, frac};
    e    = ((ex == 8'd0) ? 10'sd1 : $signed({2'b00, ex})) - 10'sd150
           + 10'($signed(cfg.scale_exp));
    cap  = cfg.signed_mode ? (neg ? 9'd128 : 9'd127) : 9'd255;
    s    = 8'(-e);
    wide    = {40'd0, m};
    shifted = '0; remmask = '0; rem = '0; half = '0; ip = '0; bump = 1'b0;
    ipr = '0; ipl = '0;
    // Magnitude rounded with ties toward plus infinity, capped.
    if (m == 24'd0) begin
      mag = 9'd0;
    end else if (e >= 10'sd0) begin
      if (e >= 10'sd8) begin
        mag = cap;
      end else begin
        ipl = 16'(m[15:0]) << e[2:0];
        mag = (m > 24'd255 || ipl > 16'(cap)) ? cap : ipl[8:0];
      end
    end else if (s > 8'd40) begin
      mag = 9'd0;
    end else begin
      shifted = wide >> s;
      remmask = (64'd1 << s) - 64'd1;
      rem     = wide & remmask;
      half    = 64'd1 << (s - 8'd1);
      bump    = neg ? (rem > half) : (rem >= half);
      ip      = shifted[40:0];
      ipr     = 42'(ip) + 42'(bump);
      mag     = (ipr > 42'(cap)) ? cap : ipr[8:0];
    end
    if (ex == 8'hFF) begin
      if (frac != 23'd0) result = 8'd0;
      else if (cfg.signed_mode) result = neg ? 8'h80 : 8'h7F;
      else result = neg ? 8'h00 : 8'hFF;
    end else if (cfg.signed_mode) begin
      result = neg ? 8'(9'd0 - mag) : mag[7:0];
    end else begin
      result = neg ? 8'd0 : mag[7:0];
    end
  end
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] value_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  quantized_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  float32_to_int8_quantizer dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic signed [5:0] pred_fix;
  logic              pred_signed;

  logic [7:0] expected_bytes[$];
  int errors = 0;
  int words_sent = 0;
  int bytes_checked = 0;
  int long_hold = 0;

  // Rounds a magnitude m * 2**e to an integer, ties up for positive values and
  // down for negative ones, capped at cap.
  function automatic logic [8:0] round_magnitude(logic [23:0] m, int e, bit neg,
                                                 logic [8:0] cap);
    logic [63:0] ip, rem, half;
    int sh;
    if (m == 0) return 9'd0;
    if (e >= 0) begin
      if (e >= 8) return cap;
      ip = 64'(m) << e;
      return (ip > 64'(cap)) ? cap : ip[8:0];
    end
    sh = -e;
    if (sh > 40) return 9'd0;
    ip = 64'(m) >> sh;
    rem = 64'(m) & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (neg ? (rem > half) : (rem >= half)) ip++;
    return (ip > 64'(cap)) ? cap : ip[8:0];
  endfunction

  function automatic logic [7:0] quantize(logic [31:0] bits);
    bit neg;
    logic [7:0] ex;
    logic [22:0] frac;
    logic [23:0] m;
    logic [8:0] mag;
    int e;
    neg = bits[31];
    ex = bits[30:23];
    frac = bits[22:0];
    if (ex == 8'hFF) begin
      if (frac != 0) return 8'h00;
      if (pred_signed) return neg ? 8'h80 : 8'h7F;
      return neg ? 8'h00 : 8'hFF;
    end
    if (ex == 0) begin
      m = {1'b0, frac};
      e = -149;
    end else begin
      m = {1'b1, frac};
      e = int'(ex) - 150;
    end
    e += pred_fix;
    if (pred_signed) begin
      mag = round_magnitude(m, e, neg, neg ? 9'd128 : 9'd127);
      return neg ? 8'(-mag) : mag[7:0];
    end
    if (neg) return 8'h00;
    mag = round_magnitude(m, e, 1'b0, 9'd255);
    return mag[7:0];
  endfunction

  task automatic write_reg(f2i8_pkg::reg_index_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == f2i8_pkg::REG_SCALE_EXP) pred_fix = data[5:0];
    else pred_signed = data[0];
    @(posedge clk);
  endtask

  // Waits until every byte has come back, then lets the clock run on with the input idle.
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offers one word; expected_known < 0 means use the predictor.
  task automatic send_word(logic [31:0] bits, int expected_known, bit no_gap);
    int gap;
    gap = no_gap ? 0 : int'($urandom_range(0, 6));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value_bits <= bits;
    do @(posedge clk); while (!in_ready);
    if (expected_known >= 0) begin
      if (8'(expected_known) != quantize(bits)) begin
        $display("%0t predictor disagrees on directed row %h: expected %h actual %h",
                 $time, bits, 8'(expected_known), quantize(bits));
        errors++;
      end
      expected_bytes.push_back(8'(expected_known));
    end else begin
      expected_bytes.push_back(quantize(bits));
    end
    words_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t unexpected byte: actual %h", $time, quantized_byte);
        errors++;
      end else begin
        if (quantized_byte !== expected_bytes[0]) begin
          $display("%0t quantized_byte mismatch: expected %h actual %h", $time,
                   expected_bytes[0], quantized_byte);
          errors++;
        end
        void'(expected_bytes.pop_front());
        bytes_checked++;
      end
    end
  end

  // Receiver stall: random wait per word, plus one long hold-off on request.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (long_hold > 0) begin
        out_ready <= 1'b0;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready) && long_hold == 0);
    end
  end

  typedef struct {
    logic [31:0] bits;
    int          expected;
  } dir_row_t;

  dir_row_t dir_rows[21] = '{
    '{32'h0000_0000, 0},    '{32'h8000_0000, 0},    '{32'h7F80_0000, 127},
    '{32'hFF80_0000, 128},  '{32'h7FC0_0000, 0},    '{32'hFFFF_FFFF, 0},
    '{32'h7F80_0001, 0},    '{32'h0000_0001, 0},    '{32'h807F_FFFF, 0},
    '{32'h4020_0000, 3},    '{32'hC020_0000, 254},  '{32'h3F00_0000, 1},
    '{32'hBF00_0000, 0},    '{32'h42FE_0000, 127},  '{32'h4300_0000, 127},
    '{32'hC300_0000, 128},  '{32'hC400_0000, 128},  '{32'h7F7F_FFFF, 127},
    '{32'h3FC0_0000, 2},    '{32'h3F80_0000, 1},    '{32'h4120_0000, 10}
  };

  int fixes[10] = '{-32, 31, 0, -1, 1, 4, -4, 7, -8, 20};

  initial begin
    logic [31:0] w;
    int unsigned kind;
    rst = 1'b1;
    pred_fix = f2i8_pkg::FixReset;
    pred_signed = f2i8_pkg::SignedReset;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i].bits, dir_rows[i].expected, 0);
    drain();

    for (int ph = 0; ph < 20; ph++) begin
      write_reg(f2i8_pkg::REG_SCALE_EXP, 32'(fixes[ph % 10]));
      write_reg(f2i8_pkg::REG_SIGNED_MODE, 32'(ph % 2));
      if (ph == 1) long_hold = 60;
      for (int k = 0; k < 85; k++) begin
        kind = $urandom_range(0, 9);
        // Mostly values whose scaled magnitude lands near the byte range.
        if (kind < 6) begin
          w = $urandom;
          w[30:23] = 8'(127 - int'(pred_fix) + int'($urandom_range(0, 12)) - 4);
        end else if (kind == 6) begin
          w = {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(0, 3))};
        end else if (kind == 7) begin
          w = {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
        end else begin
          w = $urandom;
        end
        send_word(w, -1, (ph == 1));
        if (k == 40 && ph == 3) begin
          // Sender pauses until the pipeline is empty.
          in_valid <= 1'b0;
          do @(posedge clk); while (expected_bytes.size() != 0);
        end
      end
      drain();
    end
    $display("Covered %0d words over 20 register settings, %0d bytes checked.",
             words_sent, bytes_checked);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d bytes outstanding.", expected_bytes.size());
    $display("== FAIL ==");
    $finish;
  end
endmodule
